>>> hw/rtl/audio_iir_filter_chain_unit_macros.svh
// Assertion macros shared by the audio IIR filter chain RTL.
`ifndef AUDIO_IIR_FILTER_CHAIN_UNIT_MACROS_SVH
`define AUDIO_IIR_FILTER_CHAIN_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define AIFC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AIFC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/aifc_pkg.sv
// Types, constants and arithmetic helpers of the audio IIR filter chain.
`timescale 1ns / 1ps

package aifc_pkg;

    localparam int VAL_BITS   = 48;  // Q24.24 filter state
    localparam int WIDE_BITS  = 51;  // room for sums of up to four values
    localparam int OP_BITS    = 49;  // multiplier operand (difference of two values)
    localparam int OP_LO_BITS = 24;  // low slice of the operand
    localparam int MOP_BITS   = OP_BITS - OP_LO_BITS + 1;  // one signed slice
    localparam int COEF_BITS  = 33;  // coefficient or gain, signed
    localparam int PROD_BITS  = MOP_BITS + COEF_BITS;
    localparam int ACC_BITS   = OP_BITS + COEF_BITS;

    localparam int COEF_SHIFT = 30;  // Q1.30 coefficients
    localparam int GAIN_SHIFT = 16;  // Q16.16 gain
    localparam int BIAS_SHIFT = 9;   // Q1.15 bias into Q24.24

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int UCOEF_BITS     = 31;
    localparam int GAIN_BITS      = 32;
    localparam int BIAS_BITS      = 16;
    localparam int EN_BITS        = 4;

    typedef logic signed [VAL_BITS-1:0]  val_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;
    typedef logic signed [OP_BITS-1:0]   op_t;
    typedef logic signed [MOP_BITS-1:0]  mop_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;
    typedef logic [UCOEF_BITS-1:0]       ucoef_t;
    typedef logic [EN_BITS-1:0]          en_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGE_EN  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LP_COEF   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HP_COEF   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BP_FREQ2  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BP_DAMP   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BP_SCALE  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN      = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIAS      = 3'd7;

    localparam logic signed [GAIN_BITS-1:0] GAIN_RESET = 32'sd65536;

    // Stage enable bits and the stages still pending after each stage.
    localparam int EN_LP = 0;
    localparam int EN_HP = 1;
    localparam int EN_BP = 2;
    localparam int EN_GB = 3;
    localparam en_t PEND_AFTER_LP = 4'b1110;
    localparam en_t PEND_AFTER_HP = 4'b1100;
    localparam en_t PEND_AFTER_BP = 4'b1000;

    // Substep numbers within one sample.
    localparam logic [1:0] SUB_K0 = 2'd0;
    localparam logic [1:0] SUB_K1 = 2'd1;
    localparam logic [1:0] SUB_K2 = 2'd2;
    localparam logic [1:0] SUB_K3 = 2'd3;

    localparam val_t VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};

    // Clamp a wide sum into the 48-bit state range.
    function automatic val_t sat48(input wide_t v);
        if ((&v[WIDE_BITS-1:VAL_BITS-1]) || !(|v[WIDE_BITS-1:VAL_BITS-1])) begin
            return v[VAL_BITS-1:0];
        end
        return v[WIDE_BITS-1] ? VAL_MIN : VAL_MAX;
    endfunction

    // Clamp a shifted product into the 48-bit state range.
    function automatic val_t sat_prod(input acc_t v);
        if ((&v[ACC_BITS-1:VAL_BITS-1]) || !(|v[ACC_BITS-1:VAL_BITS-1])) begin
            return v[VAL_BITS-1:0];
        end
        return v[ACC_BITS-1] ? VAL_MIN : VAL_MAX;
    endfunction

    // Linear interpolation between the previous and current stage input,
    // weights of one quarter per substep, rounded toward minus infinity.
    function automatic val_t interp(input val_t x0, input val_t x1, input logic [1:0] k);
        wide_t w0;
        wide_t w1;
        wide_t s;
        w0 = wide_t'(x0);
        w1 = wide_t'(x1);
        unique case (k)
            SUB_K0: s = ((w0 <<< 1) + w0 + w1) >>> 2;
            SUB_K1: s = (w0 + w1) >>> 1;
            SUB_K2: s = (w0 + (w1 <<< 1) + w1) >>> 2;
            SUB_K3: s = w1;
        endcase
        return val_t'(s);
    endfunction

endpackage

>>> hw/rtl/audio_iir_filter_chain_unit.sv
// Audio IIR filter chain: low-pass, high-pass, band-pass resonator, bias and gain.
`timescale 1ns / 1ps
`include "audio_iir_filter_chain_unit_macros.svh"

// This block filters one signed audio sample per transaction through an optional
// cascade of a one-pole low-pass, a one-pole high-pass, a second-order band-pass
// resonator and a bias-then-gain stage, each enabled by a bit of en_reg.
// Every filter stage runs four Euler substeps per sample on 48-bit Q24.24 state,
// and all products and sums saturate. All products go through one shared
// 26 x 33 bit signed multiplier that forms a 49 x 33 bit product in two halves,
// so every coefficient product runs as a low half, a high half and a shift and
// clamp step. The block takes one sample at a time; s_ready is high only while
// no sample is in work. A finished result waits in the output register, and the
// next sample may be accepted meanwhile; that sample only stalls at the very end
// if the previous result has still not been taken. Coefficients must be written
// through the configuration port only while the block is idle.
module audio_iir_filter_chain_unit
    import aifc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_sample_in,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [SAMPLE_BITS-1:0]   m_sample_out
);

    // Shift that moves a sample into the Q24.24 state format.
    localparam int FRAC_SHIFT = 25 - SAMPLE_BITS;

    // Sequencer states. The three multiplier states are shared by all stages
    // and return to the state held in ret_reg.
    localparam int ST_BITS = 5;
    localparam logic [ST_BITS-1:0] ST_IDLE    = 5'd0;
    localparam logic [ST_BITS-1:0] ST_LP_T    = 5'd1;
    localparam logic [ST_BITS-1:0] ST_LP_D    = 5'd2;
    localparam logic [ST_BITS-1:0] ST_LP_U    = 5'd3;
    localparam logic [ST_BITS-1:0] ST_HP_Q    = 5'd4;
    localparam logic [ST_BITS-1:0] ST_HP_U    = 5'd5;
    localparam logic [ST_BITS-1:0] ST_BP_T    = 5'd6;
    localparam logic [ST_BITS-1:0] ST_BP_M2   = 5'd7;
    localparam logic [ST_BITS-1:0] ST_BP_V    = 5'd8;
    localparam logic [ST_BITS-1:0] ST_BP_P    = 5'd9;
    localparam logic [ST_BITS-1:0] ST_BP_X    = 5'd10;
    localparam logic [ST_BITS-1:0] ST_GB      = 5'd11;
    localparam logic [ST_BITS-1:0] ST_GX      = 5'd12;
    localparam logic [ST_BITS-1:0] ST_OUT     = 5'd13;
    localparam logic [ST_BITS-1:0] ST_MUL_LO  = 5'd14;
    localparam logic [ST_BITS-1:0] ST_MUL_HI  = 5'd15;
    localparam logic [ST_BITS-1:0] ST_MUL_FIN = 5'd16;

    // Configuration registers.
    en_t                         en_reg;
    ucoef_t                      lp_coef_reg;
    ucoef_t                      hp_coef_reg;
    ucoef_t                      bp_freq2_reg;
    ucoef_t                      bp_damp_reg;
    ucoef_t                      bp_scale_reg;
    logic signed [GAIN_BITS-1:0] gain_reg;
    logic signed [BIAS_BITS-1:0] bias_reg;

    // Filter state, kept across samples.
    val_t lp_prev_reg;
    val_t lp_out_reg;
    val_t hp_prev_reg;
    val_t hp_out_reg;
    val_t bp_prev_reg;
    val_t bp_pos_reg;
    val_t bp_vel_reg;

    // Sequencer and working registers.
    logic [ST_BITS-1:0]           state_reg;
    logic [ST_BITS-1:0]           ret_reg;
    logic [1:0]                   k_reg;
    val_t                         x_reg;
    val_t                         t_reg;
    val_t                         q_reg;
    val_t                         m_reg;
    val_t                         m1_reg;
    op_t                          a_reg;
    coef_t                        c_reg;
    logic                         shift_gain_reg;
    acc_t                         acc_reg;
    logic                         m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    // Datapath signals.
    logic [1:0] k_inc;
    val_t       x_in;
    val_t       lp_sum;
    val_t       hp_sum;
    val_t       v_sum;
    val_t       p_sum;
    val_t       gb_sum;
    val_t       hp_quarter;
    wide_t      hp_diff;
    mop_t       mul_op;
    prod_t      prod;
    acc_t       prod_ext;
    acc_t       acc_sh;
    val_t       mul_res;
    val_t       out_shift;
    logic       out_in_range;
    logic signed [SAMPLE_BITS-1:0] out_sat;

    // First enabled stage among those still pending.
    function automatic logic [ST_BITS-1:0] stage_entry(input en_t pend);
        priority if (pend[EN_LP]) begin
            return ST_LP_T;
        end else if (pend[EN_HP]) begin
            return ST_HP_Q;
        end else if (pend[EN_BP]) begin
            return ST_BP_T;
        end else if (pend[EN_GB]) begin
            return ST_GB;
        end else begin
            return ST_OUT;
        end
    endfunction

    // Configuration writes. Values wider than a register are truncated.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg       <= '0;
            lp_coef_reg  <= '0;
            hp_coef_reg  <= '0;
            bp_freq2_reg <= '0;
            bp_damp_reg  <= '0;
            bp_scale_reg <= '0;
            gain_reg     <= GAIN_RESET;
            bias_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STAGE_EN: en_reg       <= cfg_data[EN_BITS-1:0];
                CFG_LP_COEF:  lp_coef_reg  <= cfg_data[UCOEF_BITS-1:0];
                CFG_HP_COEF:  hp_coef_reg  <= cfg_data[UCOEF_BITS-1:0];
                CFG_BP_FREQ2: bp_freq2_reg <= cfg_data[UCOEF_BITS-1:0];
                CFG_BP_DAMP:  bp_damp_reg  <= cfg_data[UCOEF_BITS-1:0];
                CFG_BP_SCALE: bp_scale_reg <= cfg_data[UCOEF_BITS-1:0];
                CFG_GAIN:     gain_reg     <= $signed(cfg_data[GAIN_BITS-1:0]);
                CFG_BIAS:     bias_reg     <= $signed(cfg_data[BIAS_BITS-1:0]);
            endcase
        end
    end

    // The sample is sign extended and moved up into Q24.24.
    assign x_in  = val_t'(s_sample_in) <<< FRAC_SHIFT;
    assign k_inc = k_reg + 2'd1;

    // Stage update sums, each clamped to the state range.
    assign lp_sum = sat48(wide_t'(lp_out_reg) + wide_t'(m_reg));
    assign hp_sum = sat48(wide_t'(hp_out_reg) + wide_t'(q_reg) - wide_t'(m_reg));
    assign v_sum  = sat48(wide_t'(bp_vel_reg) - wide_t'(m1_reg) - wide_t'(m_reg)
                          + wide_t'(t_reg));
    assign p_sum  = sat48(wide_t'(bp_pos_reg) + wide_t'(bp_vel_reg));
    assign gb_sum = sat48(wide_t'(x_reg) + (wide_t'(bias_reg) <<< BIAS_SHIFT));

    // The high-pass input step is spread evenly over the four substeps.
    assign hp_diff    = wide_t'(x_reg) - wide_t'(hp_prev_reg);
    assign hp_quarter = val_t'(hp_diff >>> 2);

    // Shared multiplier: the low slice of the operand is taken unsigned first,
    // then the signed high slice, which is weighted by 2^OP_LO_BITS.
    assign mul_op   = (state_reg == ST_MUL_LO)
                      ? $signed({2'b00, a_reg[OP_LO_BITS-1:0]})
                      : $signed({a_reg[OP_BITS-1], a_reg[OP_BITS-1:OP_LO_BITS]});
    assign prod     = mul_op * c_reg;
    assign prod_ext = acc_t'(prod);
    assign acc_sh   = shift_gain_reg ? (acc_reg >>> GAIN_SHIFT) : (acc_reg >>> COEF_SHIFT);
    assign mul_res  = sat_prod(acc_sh);

    // Output rounding toward minus infinity and clamping to the sample width.
    assign out_shift    = x_reg >>> FRAC_SHIFT;
    assign out_in_range = (&out_shift[VAL_BITS-1:SAMPLE_BITS-1])
                          || !(|out_shift[VAL_BITS-1:SAMPLE_BITS-1]);
    assign out_sat      = out_in_range ? out_shift[SAMPLE_BITS-1:0]
                        : (out_shift[VAL_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                                 : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            k_reg       <= SUB_K0;
            m_valid_reg <= 1'b0;
            lp_prev_reg <= '0;
            lp_out_reg  <= '0;
            hp_prev_reg <= '0;
            hp_out_reg  <= '0;
            bp_prev_reg <= '0;
            bp_pos_reg  <= '0;
            bp_vel_reg  <= '0;
        end else begin
            // In the output step the result register is refilled below instead.
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x_reg     <= x_in;
                        state_reg <= stage_entry(en_reg);
                    end
                end
                // Low-pass: y += c * (interpolated input - y), four times.
                ST_LP_T: begin
                    t_reg     <= interp(lp_prev_reg, x_reg, SUB_K0);
                    k_reg     <= SUB_K0;
                    state_reg <= ST_LP_D;
                end
                ST_LP_D: begin
                    a_reg          <= op_t'(t_reg) - op_t'(lp_out_reg);
                    c_reg          <= coef_t'({2'b00, lp_coef_reg});
                    shift_gain_reg <= 1'b0;
                    ret_reg        <= ST_LP_U;
                    state_reg      <= ST_MUL_LO;
                end
                ST_LP_U: begin
                    lp_out_reg <= lp_sum;
                    if (k_reg == SUB_K3) begin
                        lp_prev_reg <= x_reg;
                        x_reg       <= lp_sum;
                        state_reg   <= stage_entry(en_reg & PEND_AFTER_LP);
                    end else begin
                        t_reg     <= interp(lp_prev_reg, x_reg, k_inc);
                        k_reg     <= k_inc;
                        state_reg <= ST_LP_D;
                    end
                end
                // High-pass: y += quarter step - c * y, four times.
                ST_HP_Q: begin
                    q_reg          <= hp_quarter;
                    k_reg          <= SUB_K0;
                    a_reg          <= op_t'(hp_out_reg);
                    c_reg          <= coef_t'({2'b00, hp_coef_reg});
                    shift_gain_reg <= 1'b0;
                    ret_reg        <= ST_HP_U;
                    state_reg      <= ST_MUL_LO;
                end
                ST_HP_U: begin
                    hp_out_reg <= hp_sum;
                    if (k_reg == SUB_K3) begin
                        hp_prev_reg <= x_reg;
                        x_reg       <= hp_sum;
                        state_reg   <= stage_entry(en_reg & PEND_AFTER_HP);
                    end else begin
                        a_reg     <= op_t'(hp_sum);
                        k_reg     <= k_inc;
                        state_reg <= ST_MUL_LO;
                    end
                end
                // Band-pass: velocity and position of a damped resonator.
                ST_BP_T: begin
                    t_reg          <= interp(bp_prev_reg, x_reg, SUB_K0);
                    k_reg          <= SUB_K0;
                    a_reg          <= op_t'(bp_pos_reg);
                    c_reg          <= coef_t'({2'b00, bp_freq2_reg});
                    shift_gain_reg <= 1'b0;
                    ret_reg        <= ST_BP_M2;
                    state_reg      <= ST_MUL_LO;
                end
                ST_BP_M2: begin
                    m1_reg    <= m_reg;
                    a_reg     <= op_t'(bp_vel_reg);
                    c_reg     <= coef_t'({2'b00, bp_damp_reg});
                    ret_reg   <= ST_BP_V;
                    state_reg <= ST_MUL_LO;
                end
                ST_BP_V: begin
                    bp_vel_reg <= v_sum;
                    state_reg  <= ST_BP_P;
                end
                ST_BP_P: begin
                    bp_pos_reg <= p_sum;
                    a_reg      <= op_t'(p_sum);
                    state_reg  <= ST_MUL_LO;
                    if (k_reg == SUB_K3) begin
                        // The stored position stays unscaled; only the stage
                        // output is multiplied by the output scale.
                        bp_prev_reg <= x_reg;
                        c_reg       <= coef_t'({2'b00, bp_scale_reg});
                        ret_reg     <= ST_BP_X;
                    end else begin
                        t_reg   <= interp(bp_prev_reg, x_reg, k_inc);
                        k_reg   <= k_inc;
                        c_reg   <= coef_t'({2'b00, bp_freq2_reg});
                        ret_reg <= ST_BP_M2;
                    end
                end
                ST_BP_X: begin
                    x_reg     <= m_reg;
                    state_reg <= stage_entry(en_reg & PEND_AFTER_BP);
                end
                // Bias, then gain in Q16.16.
                ST_GB: begin
                    a_reg          <= op_t'(gb_sum);
                    c_reg          <= coef_t'(gain_reg);
                    shift_gain_reg <= 1'b1;
                    ret_reg        <= ST_GX;
                    state_reg      <= ST_MUL_LO;
                end
                ST_GX: begin
                    x_reg     <= m_reg;
                    state_reg <= ST_OUT;
                end
                // Load the result once the output register is free.
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg     <= out_sat;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_MUL_LO: begin
                    acc_reg   <= prod_ext;
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    acc_reg   <= acc_reg + (prod_ext <<< OP_LO_BITS);
                    state_reg <= ST_MUL_FIN;
                end
                ST_MUL_FIN: begin
                    m_reg     <= mul_res;
                    state_reg <= ret_reg;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;

    `AIFC_ASSERT_NEXT(a_accept_starts_work, aclk, aresetn, s_valid && s_ready, state_reg != ST_IDLE, "accepted sample did not start the sequencer")
    `AIFC_ASSERT_NEXT(a_mul_hi_after_lo, aclk, aresetn, state_reg == ST_MUL_LO, state_reg == ST_MUL_HI, "multiplier high half did not follow the low half")
    `AIFC_ASSERT_SAME(a_result_from_out, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_OUT, "result became valid outside the output step")
    `AIFC_ASSERT_NEXT(a_out_waits, aclk, aresetn, state_reg == ST_OUT && m_valid_reg && !m_ready, state_reg == ST_OUT && m_valid_reg, "pending result was overwritten")

endmodule
